// File: hdl/sorted_key_index_table_core_defines.svh
// assertion macros shared by the sorted key index table files
`ifndef SORTED_KEY_INDEX_TABLE_CORE_DEFINES_SVH
`define SORTED_KEY_INDEX_TABLE_CORE_DEFINES_SVH

// clocked check, quiet during reset
`define SKIT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// next-cycle implication check
`define SKIT_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// File: hdl/skit_pkg.sv
// shared types, codes and sizes of the sorted key index table
package skit_pkg;
	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	localparam logic [2:0] ACT_INSERT  = 3'd0;
	localparam logic [2:0] ACT_FIND    = 3'd1;
	localparam logic [2:0] ACT_REMOVE  = 3'd2;
	localparam logic [2:0] ACT_UPDATE  = 3'd3;
	localparam logic [2:0] ACT_COMPACT = 3'd4;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_LIVE      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	typedef struct packed {
		logic [2:0]  action;
		logic [63:0] key;
		logic [31:0] record_offset;
		logic [15:0] record_size;
		logic        entry_active;
	} cmd_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] found_offset;
		logic [15:0] found_size;
		logic [8:0]  entry_count;
	} rsp_word_t;

	typedef struct packed {
		logic [63:0] key;
		logic [31:0] offset;
		logic [15:0] size;
		logic        live;
	} rec_t;

	// commands from controller to datapath
	typedef struct packed {
		logic       load_cmd;
		logic       srch_rd;
		logic       srch_upd;
		logic       pos_rd;
		logic       wr_over;
		logic       wr_update;
		logic       wr_remove;
		logic       ins_init;
		logic       ins_rd;
		logic       ins_wr;
		logic       put_new;
		logic       cmp_init;
		logic       cmp_rd;
		logic       cmp_step;
		logic       cmp_done;
		logic       set_st;
		logic [1:0] st_code;
		logic       out_load;
	} ctl_t;

	// status from datapath to controller
	typedef struct packed {
		logic [2:0] action;
		logic       srch_more;
		logic       held;
		logic       live;
		logic       full;
		logic       ins_more;
		logic       cmp_more;
		logic       out_busy;
	} sts_t;
endpackage

// File: hdl/sorted_key_index_table_core.sv
// top level of the sorted key index table
// A table of up to 256 records kept in ascending key order in one single-port-write,
// registered-read memory. One command word is taken at a time and answered with one
// response word. Every command except compact first runs a binary search, each halving
// step a read then a compare. An insert of a new key then moves each later entry up by
// one, a read then a write per moved entry; a compact walks every held entry in the same
// manner, so these two are the slowest commands, paced by the one read and one write
// memory port. A finished response sits in an output register so the next command can
// be taken while it waits.
module sorted_key_index_table_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  skit_pkg::cmd_word_t cmd,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output skit_pkg::rsp_word_t rsp
);
	import skit_pkg::*;

	ctl_t ctl;
	sts_t sts;

	// sequencer
	skit_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	// memory and registers
	skit_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.ctl       (ctl),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);
endmodule

// File: hdl/skit_datapath.sv
// record memory, search registers and result register of the table
`include "sorted_key_index_table_core_defines.svh"
module skit_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  skit_pkg::cmd_word_t cmd,
	input  skit_pkg::ctl_t      ctl,
	output skit_pkg::sts_t      sts,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output skit_pkg::rsp_word_t rsp
);
	import skit_pkg::*;

	rec_t             mem [TABLE_DEPTH];
	rec_t             rd_q;
	cmd_word_t        cmd_q;
	logic [CNT_W-1:0] cnt_q, lo_q, hi_q, mid_q, i_q, j_q;
	logic [1:0]       st_q;
	logic [31:0]      foff_q;
	logic [15:0]      fsize_q;
	rsp_word_t        rsp_q;
	logic             rsp_valid_q;
	logic             we;
	logic [IDX_W-1:0] wa, ra;
	rec_t             wd;
	logic [CNT_W-1:0] mid;

	assign mid = lo_q + ((hi_q - lo_q) >> 1);

	// status toward the controller
	always_comb begin
		sts.action    = cmd_q.action;
		sts.srch_more = lo_q < hi_q;
		sts.held      = (lo_q < cnt_q) && (rd_q.key == cmd_q.key);
		sts.live      = rd_q.live;
		sts.full      = cnt_q >= CNT_W'(TABLE_DEPTH);
		sts.ins_more  = i_q > lo_q;
		sts.cmp_more  = i_q < cnt_q;
		sts.out_busy  = rsp_valid_q && rsp_stall;
	end

	// read address select
	always_comb begin
		ra = lo_q[IDX_W-1:0];
		if (ctl.srch_rd) begin
			ra = mid[IDX_W-1:0];
		end else if (ctl.ins_rd) begin
			ra = IDX_W'(i_q - CNT_W'(1));
		end else if (ctl.cmp_rd) begin
			ra = i_q[IDX_W-1:0];
		end
	end

	// write port select
	always_comb begin
		we = 1'b0;
		wa = lo_q[IDX_W-1:0];
		wd = rd_q;
		if (ctl.wr_over) begin
			we = 1'b1;
			wd = '{key: rd_q.key, offset: cmd_q.record_offset,
				size: cmd_q.record_size, live: cmd_q.entry_active};
		end else if (ctl.wr_update) begin
			we = 1'b1;
			wd = '{key: rd_q.key, offset: cmd_q.record_offset,
				size: cmd_q.record_size, live: rd_q.live};
		end else if (ctl.wr_remove) begin
			we = 1'b1;
			wd.live = 1'b0;
		end else if (ctl.ins_wr) begin
			we = 1'b1;
			wa = i_q[IDX_W-1:0];
		end else if (ctl.put_new) begin
			we = 1'b1;
			wd = '{key: cmd_q.key, offset: cmd_q.record_offset,
				size: cmd_q.record_size, live: cmd_q.entry_active};
		end else if (ctl.cmp_step && rd_q.live) begin
			we = 1'b1;
			wa = j_q[IDX_W-1:0];
		end
	end

	// record memory
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[ra];
	end

	// command and walk registers
	always_ff @(posedge clk) begin
		if (ctl.load_cmd) begin
			cmd_q <= cmd;
			lo_q  <= '0;
			hi_q  <= cnt_q;
		end
		if (ctl.srch_rd) begin
			mid_q <= mid;
		end
		if (ctl.srch_upd) begin
			if (rd_q.key < cmd_q.key) begin
				lo_q <= mid_q + CNT_W'(1);
			end else begin
				hi_q <= mid_q;
			end
		end
		if (ctl.ins_init) begin
			i_q <= cnt_q;
		end
		if (ctl.ins_wr) begin
			i_q <= i_q - CNT_W'(1);
		end
		if (ctl.cmp_init) begin
			i_q <= '0;
			j_q <= '0;
		end
		if (ctl.cmp_step) begin
			i_q <= i_q + CNT_W'(1);
			if (rd_q.live) begin
				j_q <= j_q + CNT_W'(1);
			end
		end
		if (ctl.set_st) begin
			st_q <= ctl.st_code;
			if (cmd_q.action == ACT_FIND && ctl.st_code == ST_OK) begin
				foff_q  <= rd_q.offset;
				fsize_q <= rd_q.size;
			end else begin
				foff_q  <= '0;
				fsize_q <= '0;
			end
		end
	end

	// held count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.put_new) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end else if (ctl.cmp_done) begin
			cnt_q <= j_q;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			rsp_q <= '{status: st_q, found_offset: foff_q, found_size: fsize_q,
				entry_count: cnt_q[8:0]};
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`SKIT_ASSERT(a_cnt_range, cnt_q <= CNT_W'(TABLE_DEPTH), "held count beyond depth")
	`SKIT_ASSERT(a_put_room, !ctl.put_new || (cnt_q < CNT_W'(TABLE_DEPTH)),
		"insert into a full table")
	`SKIT_ASSERT_NEXT(a_cmp_shrink, ctl.cmp_done, cnt_q <= $past(cnt_q),
		"compaction grew the table")
endmodule

// File: hdl/skit_controller.sv
// command sequencer of the sorted key index table
module skit_controller (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  skit_pkg::sts_t sts,
	output skit_pkg::ctl_t ctl
);
	import skit_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SRCH = 4'd1;
	localparam logic [3:0] S_SCMP = 4'd2;
	localparam logic [3:0] S_CHK  = 4'd3;
	localparam logic [3:0] S_INS  = 4'd4;
	localparam logic [3:0] S_INSW = 4'd5;
	localparam logic [3:0] S_CMP  = 4'd6;
	localparam logic [3:0] S_CMPS = 4'd7;
	localparam logic [3:0] S_OUT  = 4'd8;

	logic [3:0] state_q, state_d;

	assign cmd_stall = state_q != S_IDLE;

	// next state and datapath commands
	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					ctl.load_cmd = 1'b1;
					state_d      = S_SRCH;
				end
			end
			S_SRCH: begin
				if (sts.action == ACT_COMPACT) begin
					ctl.cmp_init = 1'b1;
					state_d      = S_CMP;
				end else if (sts.srch_more) begin
					ctl.srch_rd = 1'b1;
					state_d     = S_SCMP;
				end else begin
					ctl.pos_rd = 1'b1;
					state_d    = S_CHK;
				end
			end
			S_SCMP: begin
				ctl.srch_upd = 1'b1;
				state_d      = S_SRCH;
			end
			S_CHK: begin
				ctl.set_st = 1'b1;
				state_d    = S_OUT;
				case (sts.action)
					ACT_INSERT: begin
						if (sts.held && sts.live) begin
							ctl.st_code = ST_LIVE;
						end else if (sts.held) begin
							ctl.st_code = ST_OK;
							ctl.wr_over = 1'b1;
						end else if (sts.full) begin
							ctl.st_code = ST_FULL;
						end else begin
							ctl.st_code  = ST_OK;
							ctl.ins_init = 1'b1;
							state_d      = S_INS;
						end
					end
					ACT_FIND: begin
						ctl.st_code = (sts.held && sts.live) ? ST_OK : ST_NOT_FOUND;
					end
					ACT_REMOVE: begin
						ctl.st_code   = sts.held ? ST_OK : ST_NOT_FOUND;
						ctl.wr_remove = sts.held;
					end
					ACT_UPDATE: begin
						ctl.st_code   = sts.held ? ST_OK : ST_NOT_FOUND;
						ctl.wr_update = sts.held;
					end
					default: begin
						ctl.st_code = ST_NOT_FOUND;
					end
				endcase
			end
			S_INS: begin
				if (sts.ins_more) begin
					ctl.ins_rd = 1'b1;
					state_d    = S_INSW;
				end else begin
					ctl.put_new = 1'b1;
					state_d     = S_OUT;
				end
			end
			S_INSW: begin
				ctl.ins_wr = 1'b1;
				state_d    = S_INS;
			end
			S_CMP: begin
				if (sts.cmp_more) begin
					ctl.cmp_rd = 1'b1;
					state_d    = S_CMPS;
				end else begin
					ctl.cmp_done = 1'b1;
					ctl.set_st   = 1'b1;
					ctl.st_code  = ST_OK;
					state_d      = S_OUT;
				end
			end
			S_CMPS: begin
				ctl.cmp_step = 1'b1;
				state_d      = S_CMP;
			end
			S_OUT: begin
				if (!sts.out_busy) begin
					ctl.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule
